// File: rtl/swps_pkg.sv
// swps_pkg: shared constants and operation codes of the sliding window pair sum block
// no dependencies; imported by swps_ring, swps_ctrl and the top level
`default_nettype none

package swps_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned LIM_W     = 9;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT    = 2'd0,
    FUNC_SET_LIMIT = 2'd1,
    FUNC_QUERY     = 2'd2
  } func_t;

endpackage

`default_nettype wire

// File: rtl/swps_ring.sv
// swps_ring: ring store of value pairs, one write port and one registered read port
// depends on swps_pkg for the value width
`default_nettype none

module swps_ring #(
  parameter int unsigned DEPTH = swps_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [swps_pkg::VAL_W-1:0] wdata_a,
  input  wire logic signed [swps_pkg::VAL_W-1:0] wdata_b,
  input  wire logic [AW-1:0]                     raddr,
  output logic signed [swps_pkg::VAL_W-1:0]      rdata_a,
  output logic signed [swps_pkg::VAL_W-1:0]      rdata_b
);
  import swps_pkg::*;

  logic signed [VAL_W-1:0] mem_a [DEPTH];
  logic signed [VAL_W-1:0] mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata_a;
      mem_b[waddr] <= wdata_b;
    end
    rdata_a <= mem_a[raddr];
    rdata_b <= mem_b[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/swps_ctrl.sv
// swps_ctrl: command decode, ring pointers, running sums and result register
// depends on swps_pkg; drives the ports of swps_ring
`default_nettype none

module swps_ctrl #(
  parameter int unsigned DEPTH = swps_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [swps_pkg::FUNC_W-1:0]       in_func,
  input  wire logic signed [swps_pkg::VAL_W-1:0] in_value_a,
  input  wire logic signed [swps_pkg::VAL_W-1:0] in_value_b,
  input  wire logic [swps_pkg::LIM_W-1:0]        in_new_limit,
  output logic                                   out_valid,
  output logic signed [swps_pkg::VAL_W-1:0]      out_sum_a,
  output logic signed [swps_pkg::VAL_W-1:0]      out_sum_b,
  output logic [swps_pkg::LIM_W-1:0]             out_held_count,
  output logic                                   out_window_full,
  output logic                                   out_rejected,
  output logic                                   mem_we,
  output logic [AW-1:0]                          mem_waddr,
  output logic signed [swps_pkg::VAL_W-1:0]      mem_wdata_a,
  output logic signed [swps_pkg::VAL_W-1:0]      mem_wdata_b,
  output logic [AW-1:0]                          mem_raddr,
  input  wire logic signed [swps_pkg::VAL_W-1:0] mem_rdata_a,
  input  wire logic signed [swps_pkg::VAL_W-1:0] mem_rdata_b
);
  import swps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EVICT  = 3'b010,
    S_SHRINK = 3'b100
  } state_t;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    idx_inc = (32'(i) == DEPTH - 1) ? '0 : AW'(i + 1'b1);
  endfunction

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [AW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           limit_r, limit_nxt;
  logic signed [VAL_W-1:0] sum_a_r, sum_a_nxt;
  logic signed [VAL_W-1:0] sum_b_r, sum_b_nxt;
  logic signed [VAL_W-1:0] hold_a_r, hold_a_nxt;
  logic signed [VAL_W-1:0] hold_b_r, hold_b_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    rej_nxt;
  logic signed [VAL_W-1:0] out_sum_a_r, out_sum_b_r;
  logic [LIM_W-1:0]        out_count_r;
  logic                    out_full_r, out_rej_r;
  logic [CW-1:0]           lim_sat;

  // limits above the store depth saturate
  assign lim_sat = (32'(in_new_limit) > DEPTH) ? CW'(DEPTH) : CW'(in_new_limit);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    hold_a_nxt    = hold_a_r;
    hold_b_nxt    = hold_b_r;
    out_valid_nxt = 1'b0;
    rej_nxt       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata_a   = in_value_a;
    mem_wdata_b   = in_value_b;
    // while shrinking, fetch the entry after the one being evicted
    mem_raddr     = (state_r == S_SHRINK) ? idx_inc(head_r) : head_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_func)
            FUNC_INSERT: begin
              if (limit_r == '0) begin
                rej_nxt       = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                sum_a_nxt = sum_a_r + in_value_a;
                sum_b_nxt = sum_b_r + in_value_b;
                if (count_r >= limit_r) begin
                  // oldest word is being read at head, finish next cycle
                  hold_a_nxt = in_value_a;
                  hold_b_nxt = in_value_b;
                  state_nxt  = S_EVICT;
                end else begin
                  mem_we        = 1'b1;
                  tail_nxt      = idx_inc(tail_r);
                  count_nxt     = CW'(count_r + 1'b1);
                  out_valid_nxt = 1'b1;
                end
              end
            end
            FUNC_SET_LIMIT: begin
              limit_nxt = lim_sat;
              if (count_r > lim_sat) begin
                state_nxt = S_SHRINK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_EVICT: begin
        sum_a_nxt     = sum_a_r - mem_rdata_a;
        sum_b_nxt     = sum_b_r - mem_rdata_b;
        mem_we        = 1'b1;
        mem_wdata_a   = hold_a_r;
        mem_wdata_b   = hold_b_r;
        tail_nxt      = idx_inc(tail_r);
        head_nxt      = idx_inc(head_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SHRINK: begin
        sum_a_nxt = sum_a_r - mem_rdata_a;
        sum_b_nxt = sum_b_r - mem_rdata_b;
        head_nxt  = idx_inc(head_r);
        count_nxt = CW'(count_r - 1'b1);
        if (count_nxt == limit_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      limit_r     <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_a_r    <= hold_a_nxt;
    hold_b_r    <= hold_b_nxt;
    out_sum_a_r <= sum_a_nxt;
    out_sum_b_r <= sum_b_nxt;
    out_count_r <= LIM_W'(count_nxt);
    out_full_r  <= (count_nxt == limit_nxt);
    out_rej_r   <= rej_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_sum_a       = out_sum_a_r;
  assign out_sum_b       = out_sum_b_r;
  assign out_held_count  = out_count_r;
  assign out_window_full = out_full_r;
  assign out_rejected    = out_rej_r;

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (count_r <= limit_r))
    else $error("held count above limit while idle");

  a_shrink_above: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHRINK) |-> (count_r > limit_r))
    else $error("shrinking with nothing left to evict");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word made neither progress nor a result");

  a_evict_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVICT) |=> (out_valid && !busy))
    else $error("full insert did not finish in two cycles");

endmodule

`default_nettype wire

// File: rtl/sliding_window_pair_sum_top.sv
// sliding_window_pair_sum_top: top level of the sliding window pair sum block
// depends on swps_pkg, swps_ring and swps_ctrl
//
// usage:
// - a command word (in_func, in_value_a, in_value_b, in_new_limit) is taken at a
//   rising edge with start high and busy low: insert a pair, set the window
//   limit, or query the sums
// - every command gives exactly one result word, shown for one cycle with
//   out_valid high: both running sums (wrapping), held count, full flag and a
//   rejected flag for an insert made while the limit is zero
// - result timing and command spacing:
//   query, rejected insert, insert into a non-full window, limit that does not
//   shrink below the held count: result in the cycle after accept, next command
//   may follow in the next cycle
//   insert into a full window: busy while the S_EVICT state subtracts the
//   oldest pair, read from the ring memory, then the result
//   limit shrink evicting k pairs: one S_SHRINK step and memory read per pair
// - reset clears pointers, count, limit and sums; the ring memory is not
//   cleared and needs no clearing pass. with limit zero after reset every
//   insert is rejected until a limit is set
// - the receiver cannot stall; a result not taken in its cycle is gone
`default_nettype none

module sliding_window_pair_sum_top #(
  parameter int unsigned DEPTH = swps_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [swps_pkg::FUNC_W-1:0]       in_func,
  input  wire logic signed [swps_pkg::VAL_W-1:0] in_value_a,
  input  wire logic signed [swps_pkg::VAL_W-1:0] in_value_b,
  input  wire logic [swps_pkg::LIM_W-1:0]        in_new_limit,
  output logic                                   out_valid,
  output logic signed [swps_pkg::VAL_W-1:0]      out_sum_a,
  output logic signed [swps_pkg::VAL_W-1:0]      out_sum_b,
  output logic [swps_pkg::LIM_W-1:0]             out_held_count,
  output logic                                   out_window_full,
  output logic                                   out_rejected
);
  import swps_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata_a, mem_wdata_b;
  logic [AW-1:0]           mem_raddr;
  logic signed [VAL_W-1:0] mem_rdata_a, mem_rdata_b;

  swps_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_value_a      (in_value_a),
    .in_value_b      (in_value_b),
    .in_new_limit    (in_new_limit),
    .out_valid       (out_valid),
    .out_sum_a       (out_sum_a),
    .out_sum_b       (out_sum_b),
    .out_held_count  (out_held_count),
    .out_window_full (out_window_full),
    .out_rejected    (out_rejected),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata_a     (mem_wdata_a),
    .mem_wdata_b     (mem_wdata_b),
    .mem_raddr       (mem_raddr),
    .mem_rdata_a     (mem_rdata_a),
    .mem_rdata_b     (mem_rdata_b)
  );

  swps_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata_a (mem_wdata_a),
    .wdata_b (mem_wdata_b),
    .raddr   (mem_raddr),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

endmodule

`default_nettype wire
